### rtl/pne_pkg.sv
// -----------------------------------------------------------------------------
// pne_pkg
// Shared types and constants for the polygon nearest-edge inserter.
// -----------------------------------------------------------------------------
package pne_pkg;

	// Default configuration of the vertex store
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 12;

	// Fixed payload field widths
	localparam int CMD_W    = 2;
	localparam int POINT_W  = 12;
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_DONE    = 1'b0;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 1'b1;

endpackage

### rtl/pne_if.sv
// -----------------------------------------------------------------------------
// pne_req_if / pne_rsp_if
// Valid/ready channels carrying edit commands and their results.
// -----------------------------------------------------------------------------
interface pne_req_if;
	logic                        valid;
	logic                        ready;
	logic [pne_pkg::CMD_W-1:0]   cmd;
	logic [pne_pkg::POINT_W-1:0] point_x;
	logic [pne_pkg::POINT_W-1:0] point_y;

	modport source (output valid, cmd, point_x, point_y, input ready);
	modport sink   (input valid, cmd, point_x, point_y, output ready);
endinterface

interface pne_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pne_pkg::IDX_W-1:0]    placed_index;
	logic [pne_pkg::IDX_W-1:0]    vertex_total;
	logic [pne_pkg::STATUS_W-1:0] status;

	modport source (output valid, placed_index, vertex_total, status, input ready);
	modport sink   (input valid, placed_index, vertex_total, status, output ready);
endinterface

### rtl/pne_mul.sv
// -----------------------------------------------------------------------------
// pne_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module pne_mul #(
	parameter int A_W = 52,
	parameter int B_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic             done,
	output logic [A_W+B_W-1:0] product
);
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   acc_q;
	logic [P_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			acc_q  <= '0;
			a_q    <= P_W'(a);
			b_q    <= b;
			cnt_q  <= CNT_W'(B_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			// add the shifted multiplicand for each set multiplier bit
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q   <= a_q << 1;
			b_q   <= b_q >> 1;
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### rtl/polygon_nearest_edge_inserter.sv
// -----------------------------------------------------------------------------
// polygon_nearest_edge_inserter
// Closed-polygon vertex store with append, nearest-edge insert and clear.
// -----------------------------------------------------------------------------
// Usage:
//   req carries one edit per transaction: append, insert at nearest edge or
//   clear, with a point. rsp returns one transaction per edit: the index the
//   point now holds, the vertex total and a dropped flag for a full store.
//   req.ready is high only while the block is idle; one edit is in work at a
//   time. A finished result sits in the rsp register, so the next edit may
//   be taken while the receiver stalls; that edit then holds at its end
//   until the register frees up.
// Sequence:
//   clear / drop / unknown command: straight to the result stage.
//   append: a write, then the result. insert: an edge search over all edges,
//   then each entry from the insert index on moves up one, a write and the
//   result. Edge search: every edge uses the one shift-add multiplier, one
//   product after another; an edge needs 6 to 9 products, reads and control.
// Reset: arst_n clears the vertex count and the output valid; the vertex
//   memory is not cleared, entries at or above the count are never used.
// -----------------------------------------------------------------------------
module polygon_nearest_edge_inserter #(
	parameter int MAX_VERTICES = pne_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pne_pkg::COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pne_req_if.sink    req,
	pne_rsp_if.source  rsp
);
	localparam int C      = COORD_BITS;
	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int CW     = $clog2(MAX_VERTICES + 1);
	localparam int ACC_W  = 2 * C + 4;   // signed dot and cross sums
	localparam int LEN_W  = 2 * C + 1;   // squared edge length
	localparam int MB     = 2 * C + 2;   // multiplier operand b
	localparam int PA     = 4 * C + 4;   // multiplier operand a, squared distance
	localparam int PW     = PA + MB;     // full product
	localparam int IDX_W  = pne_pkg::IDX_W;

	// difference slots
	localparam int D_AXP = 0;
	localparam int D_AYP = 1;
	localparam int D_DX  = 2;
	localparam int D_DY  = 3;
	localparam int D_BXP = 4;
	localparam int D_BYP = 5;

	typedef enum logic [4:0] {
		S_IDLE, S_RDA, S_RDB, S_LATB, S_MSTART, S_MWAIT, S_CMP, S_TAKE,
		S_ADV, S_SHCHK, S_SHR, S_SHW, S_WR, S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_DOT1, OP_DOT2, OP_LEN1, OP_LEN2, OP_NA1, OP_NA2, OP_NB1, OP_NB2,
		OP_CR1, OP_CR2, OP_CC, OP_LHS, OP_RHS
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [C-1:0]   px_q, py_q, ax_q, ay_q;
	logic [CW-1:0]  count_q, i_q, best_q, idx_q, j_q, res_idx_q;
	logic [pne_pkg::STATUS_W-1:0] res_status_q;
	logic [C:0]     mag_q [6];
	logic           sgn_q [6];
	logic signed [ACC_W-1:0] acc_q, dot_q;
	logic [LEN_W-1:0] len_q, den_q, best_den_q;
	logic [MB-1:0]    cmag_q;
	logic [PA-1:0]    num_q, best_num_q;
	logic [PW-1:0]    lhs_q;

	logic             rsp_valid_q;
	logic [IDX_W-1:0] rsp_idx_q, rsp_total_q;
	logic [pne_pkg::STATUS_W-1:0] rsp_status_q;

	// vertex memory, {y, x} per entry
	logic [2*C-1:0] mem [MAX_VERTICES];
	logic [2*C-1:0] rd_q;
	logic           mem_we;
	logic [AW-1:0]  mem_wa, mem_ra;
	logic [2*C-1:0] mem_wd;

	// shared multiplier
	logic           mul_start, mul_done;
	logic [PA-1:0]  mul_a;
	logic [MB-1:0]  mul_b;
	logic [PW-1:0]  mul_p;
	logic           op_neg;

	logic [CW-1:0]  i_p1, nx, j_m1;
	logic [C-1:0]   bx, by;
	logic signed [ACC_W-1:0] term, sum;
	logic [LEN_W-1:0] len_new;
	logic [MB-1:0]    cross_mag;
	pne_pkg::cmd_t    req_cmd;

	pne_mul #(
		.A_W (PA),
		.B_W (MB)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	// magnitude of a - b
	function automatic logic [C:0] diff_mag(logic [C-1:0] a, logic [C-1:0] b);
		logic [C:0] d;
		d = {1'b0, a} - {1'b0, b};
		return d[C] ? -d : d;
	endfunction

	assign req_cmd = pne_pkg::cmd_t'(req.cmd);
	assign i_p1    = i_q + CW'(1);
	assign nx      = (i_p1 == count_q) ? '0 : i_p1;
	assign j_m1    = j_q - CW'(1);
	assign bx      = rd_q[C-1:0];
	assign by      = rd_q[2*C-1:C];

	// operand select for the current product
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		op_neg = 1'b0;
		case (op_q)
			OP_DOT1: begin
				mul_a = PA'(mag_q[D_AXP]); mul_b = MB'(mag_q[D_DX]);
				op_neg = sgn_q[D_AXP] ^ sgn_q[D_DX];
			end
			OP_DOT2: begin
				mul_a = PA'(mag_q[D_AYP]); mul_b = MB'(mag_q[D_DY]);
				op_neg = sgn_q[D_AYP] ^ sgn_q[D_DY];
			end
			OP_LEN1: begin mul_a = PA'(mag_q[D_DX]);  mul_b = MB'(mag_q[D_DX]);  end
			OP_LEN2: begin mul_a = PA'(mag_q[D_DY]);  mul_b = MB'(mag_q[D_DY]);  end
			OP_NA1:  begin mul_a = PA'(mag_q[D_AXP]); mul_b = MB'(mag_q[D_AXP]); end
			OP_NA2:  begin mul_a = PA'(mag_q[D_AYP]); mul_b = MB'(mag_q[D_AYP]); end
			OP_NB1:  begin mul_a = PA'(mag_q[D_BXP]); mul_b = MB'(mag_q[D_BXP]); end
			OP_NB2:  begin mul_a = PA'(mag_q[D_BYP]); mul_b = MB'(mag_q[D_BYP]); end
			OP_CR1: begin
				mul_a = PA'(mag_q[D_AXP]); mul_b = MB'(mag_q[D_DY]);
				op_neg = sgn_q[D_AXP] ^ sgn_q[D_DY];
			end
			OP_CR2: begin
				// subtracted term
				mul_a = PA'(mag_q[D_AYP]); mul_b = MB'(mag_q[D_DX]);
				op_neg = ~(sgn_q[D_AYP] ^ sgn_q[D_DX]);
			end
			OP_CC:  begin mul_a = PA'(cmag_q); mul_b = cmag_q;           end
			OP_LHS: begin mul_a = num_q;       mul_b = MB'(best_den_q);  end
			OP_RHS: begin mul_a = best_num_q;  mul_b = MB'(den_q);       end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		term      = op_neg ? -$signed(mul_p[ACC_W-1:0]) : $signed(mul_p[ACC_W-1:0]);
		sum       = acc_q + term;
		len_new   = sum[LEN_W-1:0];
		cross_mag = sum[ACC_W-1] ? MB'(-sum) : MB'(sum);
	end

	assign mul_start = (state_q == S_MSTART);

	// memory port control
	always_comb begin
		mem_ra = i_q[AW-1:0];
		mem_we = 1'b0;
		mem_wa = j_q[AW-1:0];
		mem_wd = rd_q;
		case (state_q)
			S_RDB: mem_ra = nx[AW-1:0];
			S_SHR: mem_ra = j_m1[AW-1:0];
			S_SHW: mem_we = 1'b1;
			S_WR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
				mem_wd = {py_q, px_q};
			end
			default: mem_ra = i_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the sent result; the result stage reloads the register itself
			if (rsp.valid && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						px_q         <= C'(req.point_x);
						py_q         <= C'(req.point_y);
						res_idx_q    <= '0;
						res_status_q <= pne_pkg::ST_DONE;
						case (req_cmd)
							pne_pkg::CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							pne_pkg::CMD_APPEND, pne_pkg::CMD_INSERT: begin
								if (count_q >= CW'(MAX_VERTICES)) begin
									// full store: drop the point
									res_status_q <= pne_pkg::ST_DROPPED;
									state_q      <= S_RESP;
								end else if (req_cmd == pne_pkg::CMD_INSERT &&
								             count_q >= CW'(2)) begin
									i_q     <= '0;
									state_q <= S_RDA;
								end else begin
									idx_q   <= count_q;
									j_q     <= count_q;
									state_q <= S_SHCHK;
								end
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					ax_q    <= rd_q[C-1:0];
					ay_q    <= rd_q[2*C-1:C];
					state_q <= S_LATB;
				end
				S_LATB: begin
					mag_q[D_AXP] <= diff_mag(px_q, ax_q); sgn_q[D_AXP] <= px_q < ax_q;
					mag_q[D_AYP] <= diff_mag(py_q, ay_q); sgn_q[D_AYP] <= py_q < ay_q;
					mag_q[D_DX]  <= diff_mag(bx, ax_q);   sgn_q[D_DX]  <= bx < ax_q;
					mag_q[D_DY]  <= diff_mag(by, ay_q);   sgn_q[D_DY]  <= by < ay_q;
					mag_q[D_BXP] <= diff_mag(px_q, bx);   sgn_q[D_BXP] <= px_q < bx;
					mag_q[D_BYP] <= diff_mag(py_q, by);   sgn_q[D_BYP] <= py_q < by;
					op_q    <= OP_DOT1;
					state_q <= S_MSTART;
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						state_q <= S_MSTART;
						case (op_q)
							OP_DOT1: begin acc_q <= term; op_q <= OP_DOT2; end
							OP_DOT2: begin dot_q <= sum;  op_q <= OP_LEN1; end
							OP_LEN1: begin acc_q <= term; op_q <= OP_LEN2; end
							OP_LEN2: begin
								len_q <= len_new;
								// pick the clamped end or the interior distance
								if (dot_q <= 0) begin
									op_q <= OP_NA1;
								end else if (dot_q >= $signed(ACC_W'(len_new))) begin
									op_q <= OP_NB1;
								end else begin
									op_q <= OP_CR1;
								end
							end
							OP_NA1, OP_NB1, OP_CR1: begin
								acc_q <= term;
								op_q  <= (op_q == OP_NA1) ? OP_NA2 :
								         (op_q == OP_NB1) ? OP_NB2 : OP_CR2;
							end
							OP_NA2, OP_NB2: begin
								num_q   <= PA'(sum[LEN_W:0]);
								den_q   <= LEN_W'(1);
								state_q <= S_CMP;
							end
							OP_CR2: begin cmag_q <= cross_mag; op_q <= OP_CC; end
							OP_CC: begin
								num_q   <= mul_p[PA-1:0];
								den_q   <= len_q;
								state_q <= S_CMP;
							end
							OP_LHS: begin lhs_q <= mul_p; op_q <= OP_RHS; end
							OP_RHS: begin
								// strictly nearer only, so ties keep the earlier edge
								state_q <= (lhs_q < mul_p) ? S_TAKE : S_ADV;
							end
							default: state_q <= S_ADV;
						endcase
					end
				end
				S_CMP: begin
					if (i_q == '0) begin
						state_q <= S_TAKE;
					end else begin
						op_q    <= OP_LHS;
						state_q <= S_MSTART;
					end
				end
				S_TAKE: begin
					best_num_q <= num_q;
					best_den_q <= den_q;
					best_q     <= nx;
					state_q    <= S_ADV;
				end
				S_ADV: begin
					if (nx == '0) begin
						idx_q   <= best_q;
						j_q     <= count_q;
						state_q <= S_SHCHK;
					end else begin
						i_q     <= i_p1;
						state_q <= S_RDA;
					end
				end
				S_SHCHK: state_q <= (j_q > idx_q) ? S_SHR : S_WR;
				S_SHR:   state_q <= S_SHW;
				S_SHW: begin
					// move entry j-1 up to j
					j_q     <= j_m1;
					state_q <= S_SHCHK;
				end
				S_WR: begin
					count_q   <= count_q + CW'(1);
					res_idx_q <= idx_q;
					state_q   <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_idx_q    <= IDX_W'(res_idx_q);
						rsp_total_q  <= IDX_W'(count_q);
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.placed_index = rsp_idx_q;
	assign rsp.vertex_total = rsp_total_q;
	assign rsp.status       = rsp_status_q;

endmodule

### rtl/pne_checker.sv
// -----------------------------------------------------------------------------
// pne_checker
// Port-level checks for the polygon nearest-edge inserter.
// -----------------------------------------------------------------------------
module pne_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [pne_pkg::IDX_W-1:0]    rsp_placed_index,
	input logic [pne_pkg::IDX_W-1:0]    rsp_vertex_total,
	input logic [pne_pkg::STATUS_W-1:0] rsp_status
);
	// one edit in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted while an edit is in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_placed_index) &&
		$stable(rsp_vertex_total) && $stable(rsp_status))
		else $error("stalled rsp transaction changed");

	a_drop_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == pne_pkg::ST_DROPPED |-> rsp_placed_index == '0)
		else $error("dropped point reports a non-zero index");

	a_index_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == pne_pkg::ST_DONE |->
		rsp_placed_index <= rsp_vertex_total)
		else $error("placed index beyond vertex total");

endmodule

bind polygon_nearest_edge_inserter pne_checker u_pne_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_placed_index (rsp.placed_index),
	.rsp_vertex_total (rsp.vertex_total),
	.rsp_status       (rsp.status)
);

### tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_nearest_edge_inserter. A queue of edits
// (append, nearest-edge insert, clear, unused command) is driven through the
// req channel with random gaps, while an internal vertex-list predictor works
// out each result. Results are compared field by field on the rsp channel.
// -----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CMD_W      = pne_pkg::CMD_W;
	localparam int POINT_W    = pne_pkg::POINT_W;
	localparam int IDX_W      = pne_pkg::IDX_W;
	localparam int STATUS_W   = pne_pkg::STATUS_W;
	localparam int MAXV       = pne_pkg::MAX_VERTICES_DEF;
	localparam int IDLE_LIMIT = 200000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [POINT_W-1:0] x;
		logic [POINT_W-1:0] y;
	} edit_t;

	typedef struct packed {
		logic [IDX_W-1:0]    placed;
		logic [IDX_W-1:0]    total;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pne_req_if req ();
	pne_rsp_if rsp ();

	polygon_nearest_edge_inserter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #2 clk = ~clk;

	edit_t    pending_edits[$];
	outcome_t expected_outcomes[$];
	int       total_edits;
	int       taken_edits = 0;
	int       errors = 0;
	int       idle_cycles = 0;
	bit       req_fired = 1'b0;
	bit       stimulus_done = 1'b0;
	int       hold_cycles = 0;
	bit       hold_started = 1'b0;

	// Predictor's own copy of the polygon
	logic [POINT_W-1:0] poly_x[MAXV];
	logic [POINT_W-1:0] poly_y[MAXV];
	int                 poly_n = 0;

	// Squared distance from the point to edge a->b, as num / den
	function automatic void edge_sq_dist(input longint px, input longint py,
			input int a, input int b, output logic [127:0] num,
			output logic [127:0] den);
		longint axp, ayp, dx, dy, dot, len, bxp, byp, c;
		axp = px - longint'(poly_x[a]);
		ayp = py - longint'(poly_y[a]);
		dx  = longint'(poly_x[b]) - longint'(poly_x[a]);
		dy  = longint'(poly_y[b]) - longint'(poly_y[a]);
		dot = axp * dx + ayp * dy;
		len = dx * dx + dy * dy;
		if (dot <= 0) begin
			num = 128'(axp * axp + ayp * ayp);
			den = 128'd1;
		end else if (dot >= len) begin
			bxp = px - longint'(poly_x[b]);
			byp = py - longint'(poly_y[b]);
			num = 128'(bxp * bxp + byp * byp);
			den = 128'd1;
		end else begin
			c = axp * dy - ayp * dx;
			if (c < 0)
				c = -c;
			num = 128'(c) * 128'(c);
			den = 128'(len);
		end
	endfunction

	// Apply one edit to the predicted polygon and return its outcome
	function automatic outcome_t apply_edit(edit_t e);
		outcome_t o;
		int idx, best, nx;
		logic [127:0] num, den, best_num, best_den;
		o = '0;
		if (e.cmd == pne_pkg::CMD_CLEAR) begin
			poly_n = 0;
		end else if (e.cmd == pne_pkg::CMD_APPEND || e.cmd == pne_pkg::CMD_INSERT) begin
			if (poly_n >= MAXV) begin
				o.status = pne_pkg::ST_DROPPED;
			end else begin
				idx = poly_n;
				if (e.cmd == pne_pkg::CMD_INSERT && poly_n >= 2) begin
					best = 1;
					best_num = '0;
					best_den = 128'd1;
					for (int i = 0; i < poly_n; i++) begin
						nx = (i + 1 == poly_n) ? 0 : i + 1;
						edge_sq_dist(longint'(e.x), longint'(e.y), i, nx, num, den);
						// strictly nearer only, so the earliest tie holds
						if (i == 0 || num * best_den < best_num * den) begin
							best_num = num;
							best_den = den;
							best = nx;
						end
					end
					idx = best;
				end
				for (int j = poly_n; j > idx; j--) begin
					poly_x[j] = poly_x[j-1];
					poly_y[j] = poly_y[j-1];
				end
				poly_x[idx] = e.x;
				poly_y[idx] = e.y;
				poly_n++;
				o.placed = IDX_W'(idx);
				o.status = pne_pkg::ST_DONE;
			end
		end
		o.total = IDX_W'(poly_n);
		return o;
	endfunction

	// Idling phases: first third sender idles 26%, receiver 52%; then swapped;
	// then neither idles
	function automatic bit sender_idles();
		if (taken_edits < total_edits / 3)
			return $urandom_range(99) < 26;
		if (taken_edits < 2 * total_edits / 3)
			return $urandom_range(99) < 52;
		return 1'b0;
	endfunction

	function automatic bit receiver_idles();
		if (taken_edits < total_edits / 3)
			return $urandom_range(99) < 52;
		if (taken_edits < 2 * total_edits / 3)
			return $urandom_range(99) < 26;
		return 1'b0;
	endfunction

	// Driver: change inputs at the falling edge; hold an offered transaction
	// until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid   <= 1'b0;
			req.cmd     <= pne_pkg::CMD_APPEND;
			req.point_x <= '0;
			req.point_y <= '0;
		end else if (req.valid && !req_fired) begin
			req.valid <= 1'b1;
		end else if (pending_edits.size() > 0 && !sender_idles()) begin
			req.valid   <= 1'b1;
			req.cmd     <= pending_edits[0].cmd;
			req.point_x <= pending_edits[0].x;
			req.point_y <= pending_edits[0].y;
		end else begin
			req.valid <= 1'b0;
		end
	end

	// Long receiver hold-off once, so the result register fills and req stalls
	always @(negedge clk) begin
		if (!hold_started && taken_edits >= 60) begin
			hold_started <= 1'b1;
			hold_cycles  <= 3000;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
		if (!arst_n || hold_cycles > 1 || (!hold_started && taken_edits >= 60))
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !receiver_idles();
	end

	// Monitor: sample both channels at the rising edge, predict, compare
	always @(posedge clk) begin
		outcome_t got, want;
		req_fired <= arst_n && req.valid && req.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_outcomes = {expected_outcomes,
					apply_edit(pending_edits.pop_front())};
				taken_edits <= taken_edits + 1;
			end
			if (rsp.valid && rsp.ready) begin
				got.placed = rsp.placed_index;
				got.total  = rsp.vertex_total;
				got.status = rsp.status;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result placed=%0d total=%0d status=%0d",
						$time, got.placed, got.total, got.status);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					if (got.placed !== want.placed) begin
						$display("%0t: placed_index expected %0d actual %0d",
							$time, want.placed, got.placed);
						errors++;
					end
					if (got.total !== want.total) begin
						$display("%0t: vertex_total expected %0d actual %0d",
							$time, want.total, got.total);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						errors++;
					end
				end
			end
			// Watchdog: count cycles with no transaction on either side
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else if (!stimulus_done || expected_outcomes.size() > 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Stimulus generation helpers
	task automatic add_edit(logic [CMD_W-1:0] c, int x, int y);
		edit_t e;
		e.cmd = c;
		e.x   = POINT_W'(x);
		e.y   = POINT_W'(y);
		pending_edits = {pending_edits, e};
	endtask

	function automatic int rand_coord(bit narrow);
		if (narrow)
			return int'($urandom_range(15)) + 2000;
		return int'($urandom_range(4095));
	endfunction

	initial begin
		int run_len, r;
		bit narrow;

		// Directed: empty and single-vertex insert, extremes, closing edge,
		// ties, zero-length edge, unused command, clear
		add_edit(pne_pkg::CMD_INSERT, 0, 0);          // empty list: acts as append
		add_edit(pne_pkg::CMD_INSERT, 4095, 4095);    // one vertex: acts as append
		add_edit(pne_pkg::CMD_APPEND, 4095, 0);
		add_edit(pne_pkg::CMD_INSERT, 0, 4095);       // first edge nearest: index 1
		add_edit(pne_pkg::CMD_INSERT, 2048, 2048);    // equidistant from two edges: earlier edge
		add_edit(CMD_UNUSED, 4095, 4095);
		add_edit(pne_pkg::CMD_CLEAR, 0, 0);
		add_edit(pne_pkg::CMD_APPEND, 100, 100);
		add_edit(pne_pkg::CMD_APPEND, 100, 100);      // zero-length edge
		add_edit(pne_pkg::CMD_INSERT, 100, 100);
		add_edit(pne_pkg::CMD_INSERT, 200, 50);
		add_edit(pne_pkg::CMD_CLEAR, 4095, 4095);
		add_edit(pne_pkg::CMD_APPEND, 0, 0);
		add_edit(pne_pkg::CMD_APPEND, 10, 0);
		add_edit(pne_pkg::CMD_APPEND, 10, 10);
		add_edit(pne_pkg::CMD_APPEND, 0, 10);
		add_edit(pne_pkg::CMD_INSERT, 5, 5);          // square centre: four-way tie
		add_edit(pne_pkg::CMD_INSERT, 5, 4095);
		add_edit(pne_pkg::CMD_INSERT, 4095, 5);
		add_edit(pne_pkg::CMD_CLEAR, 0, 0);

		// Random: mostly short polygons built then cleared; sometimes a fill
		// to a full store with drops; some noise
		while (pending_edits.size() < 1770) begin
			r = int'($urandom_range(99));
			narrow = $urandom_range(3) == 0;
			if (r < 5) begin
				for (int i = 0; i < MAXV; i++)
					add_edit(pne_pkg::CMD_APPEND, rand_coord(narrow), rand_coord(narrow));
				for (int i = 0; i < 4; i++)
					add_edit($urandom_range(1) ? pne_pkg::CMD_INSERT : pne_pkg::CMD_APPEND,
						rand_coord(0), rand_coord(0));
				add_edit(pne_pkg::CMD_CLEAR, rand_coord(0), rand_coord(0));
			end else if (r < 7) begin
				// three deep inserts into a nearly full polygon
				for (int i = 0; i < MAXV - 2; i++)
					add_edit(pne_pkg::CMD_APPEND, rand_coord(narrow), rand_coord(narrow));
				add_edit(pne_pkg::CMD_INSERT, rand_coord(narrow), rand_coord(narrow));
				add_edit(pne_pkg::CMD_INSERT, rand_coord(narrow), rand_coord(narrow));
				add_edit(pne_pkg::CMD_INSERT, rand_coord(narrow), rand_coord(narrow));
				add_edit(pne_pkg::CMD_CLEAR, 0, 0);
			end else if (r < 12) begin
				add_edit(CMD_W'($urandom_range(3)), rand_coord(0), rand_coord(0));
			end else begin
				run_len = int'($urandom_range(10, 1));
				for (int i = 0; i < run_len; i++) begin
					add_edit(($urandom_range(2) == 0) ? pne_pkg::CMD_APPEND :
						pne_pkg::CMD_INSERT, rand_coord(narrow), rand_coord(narrow));
				end
				if ($urandom_range(3) != 0)
					add_edit(pne_pkg::CMD_CLEAR, rand_coord(0), rand_coord(0));
			end
		end
		total_edits = pending_edits.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_edits.size() == 0);
		stimulus_done = 1'b1;
		wait (expected_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_outcomes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

### filelist.f
rtl/pne_pkg.sv
rtl/pne_if.sv
rtl/pne_mul.sv
rtl/polygon_nearest_edge_inserter.sv
rtl/pne_checker.sv
tb/testbench.sv
